@@ src/sdbp_pkg.sv @@
// ----------------------------------------------------------------------------
// sdbp_pkg
// Shared types, codes and helpers for the slew-rate dual update block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdbp_pkg;

   // Default sizing
   localparam int SDBP_MAX_POINTS = 1024;
   localparam int SDBP_FRAC_BITS  = 16;

   // Width of one exact product and of the accumulator
   localparam int PROD_W = 65;

   // Configuration reset values
   localparam logic [30:0] WEIGHT_RST       = 31'd65536;
   localparam logic [30:0] DUAL_STEP_RST    = 31'd32768;
   localparam logic [30:0] CLAMP_LIMIT_RST  = 31'd0;
   localparam logic [17:0] RELAX_FACTOR_RST = 18'd65536;
   localparam logic [10:0] VECTOR_LEN_RST   = 11'd1024;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_WEIGHT       = 3'd0,
      CSR_DUAL_STEP    = 3'd1,
      CSR_CLAMP_LIMIT  = 3'd2,
      CSR_RELAX_FACTOR = 3'd3,
      CSR_VECTOR_LEN   = 3'd4
   } csr_index_type;

   // Request operations
   typedef enum logic [1:0] {
      OP_UPDATE  = 2'd0,
      OP_ADJOINT = 2'd1,
      OP_SCALE   = 2'd2
   } op_type;

   // Result kinds
   typedef enum logic {
      KIND_DUAL    = 1'b0,
      KIND_ADJOINT = 1'b1
   } kind_type;

   // How the adjoint difference is formed
   typedef enum logic [1:0] {
      ADJ_NEG  = 2'd0,
      ADJ_POS  = 2'd1,
      ADJ_DIFF = 2'd2
   } adj_type;

   // Sequencer steps
   typedef enum logic [13:0] {
      ST_CLEAR  = 14'b00_0000_0000_0001,
      ST_IDLE   = 14'b00_0000_0000_0010,
      ST_LOAD   = 14'b00_0000_0000_0100,
      ST_ADJ_D  = 14'b00_0000_0000_1000,
      ST_MUL_T  = 14'b00_0000_0001_0000,
      ST_CLAMP  = 14'b00_0000_0010_0000,
      ST_MUL_S  = 14'b00_0000_0100_0000,
      ST_ZBAR   = 14'b00_0000_1000_0000,
      ST_MUL_R1 = 14'b00_0001_0000_0000,
      ST_MUL_R2 = 14'b00_0010_0000_0000,
      ST_SUM    = 14'b00_0100_0000_0000,
      ST_MUL_X  = 14'b00_1000_0000_0000,
      ST_RND    = 14'b01_0000_0000_0000,
      ST_DONE   = 14'b10_0000_0000_0000
   } step_type;

   // Configuration registers
   typedef struct packed {
      logic [30:0] weight;
      logic [30:0] dual_step;
      logic [30:0] clamp_limit;
      logic [17:0] relax_factor;
      logic [10:0] vector_length;
   } cfg_type;

   // Sequencer to datapath control
   typedef struct packed {
      step_type step;
      adj_type  adj;
      logic     is_scale;
      logic     accept;
      logic     prev_take;
      logic     emit;
   } ctrl_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat_word(input logic signed [PROD_W-1:0] v);
      logic in_range;
      in_range = (&v[PROD_W-1:31]) | ~(|v[PROD_W-1:31]);
      if (in_range) begin
         return v[31:0];
      end else if (v[PROD_W-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

   // Sign-extend a word to product width
   function automatic logic signed [PROD_W-1:0] sext_word(input logic signed [31:0] v);
      return {{(PROD_W-32){v[31]}}, v};
   endfunction

endpackage

`default_nettype wire

@@ src/sdbp_dual_ram.sv @@
// ----------------------------------------------------------------------------
// sdbp_dual_ram
// Dual vector storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbp_dual_ram #(
   parameter int DEPTH = sdbp_pkg::SDBP_MAX_POINTS,
   parameter int AW    = $clog2(sdbp_pkg::SDBP_MAX_POINTS)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic signed [31:0]   wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output      logic signed [31:0]   rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/sdbp_datapath.sv @@
// ----------------------------------------------------------------------------
// sdbp_datapath
// Operand registers, the shared multiplier and the rounding/saturation logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbp_datapath #(
   parameter int FRAC_BITS = sdbp_pkg::SDBP_FRAC_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sdbp_pkg::ctrl_type          ctrl,
   input  wire sdbp_pkg::cfg_type           cfg,
   input  wire logic signed [31:0]          sample_value,
   input  wire logic [30:0]                 scale_factor,
   input  wire logic signed [31:0]          mem_rdata,
   output      logic signed [31:0]          mem_wdata,
   output      logic signed [31:0]          result_value
);

   import sdbp_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_T = PROD_W'(1) << (FRAC_BITS - 2);
   localparam logic signed [PROD_W-1:0] HALF_F = PROD_W'(1) << (FRAC_BITS - 1);

   logic signed [31:0]        prev_ff, prev_in;
   logic signed [32:0]        h_ff, h_in;
   logic [30:0]               scale_ff, scale_in;
   logic signed [31:0]        zold_ff, zold_in;
   logic signed [31:0]        b_ff, b_in;
   logic signed [31:0]        t_ff, t_in;
   logic signed [31:0]        zbar_ff, zbar_in;
   logic signed [32:0]        d_ff, d_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]        res_ff, res_in;
   logic signed [31:0]        out_ff, out_in;

   logic signed [33:0]        diff;
   logic signed [32:0]        mul_a;
   logic signed [31:0]        mul_b;
   logic signed [31:0]        one_m_relax;
   logic signed [31:0]        lim;
   logic signed [31:0]        t_raw;
   logic                      mul_step;

   // Shared multiplier operand selection
   always_comb begin
      mul_a       = '0;
      mul_b       = '0;
      mul_step    = 1'b0;
      one_m_relax = (32'sd1 <<< FRAC_BITS) - $signed({14'b0, cfg.relax_factor});
      case (ctrl.step)
         ST_MUL_T: begin
            mul_a    = {b_ff[31], b_ff};
            mul_b    = {1'b0, cfg.weight};
            mul_step = 1'b1;
         end
         ST_MUL_S: begin
            mul_a    = {t_ff[31], t_ff};
            mul_b    = {1'b0, cfg.dual_step};
            mul_step = 1'b1;
         end
         ST_MUL_R1: begin
            mul_a    = {zbar_ff[31], zbar_ff};
            mul_b    = {14'b0, cfg.relax_factor};
            mul_step = 1'b1;
         end
         ST_MUL_R2: begin
            mul_a    = {zold_ff[31], zold_ff};
            mul_b    = one_m_relax;
            mul_step = 1'b1;
         end
         ST_MUL_X: begin
            if (ctrl.is_scale) begin
               mul_a = {zold_ff[31], zold_ff};
               mul_b = {1'b0, scale_ff};
            end else begin
               mul_a = d_ff;
               mul_b = {1'b0, cfg.weight};
            end
            mul_step = 1'b1;
         end
         default: begin
            mul_step = 1'b0;
         end
      endcase
   end

   // Next values of the working registers
   always_comb begin
      prev_in  = prev_ff;
      h_in     = h_ff;
      scale_in = scale_ff;
      zold_in  = zold_ff;
      b_in     = b_ff;
      t_in     = t_ff;
      zbar_in  = zbar_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      prod_in  = mul_step ? (mul_a * mul_b) : prod_ff;

      // Half difference to the previous sample, rounded up on ties
      diff  = {{2{sample_value[31]}}, sample_value} - {{2{prev_ff[31]}}, prev_ff} + 34'sd1;
      lim   = $signed({1'b0, cfg.clamp_limit});
      t_raw = sat_word((prod_ff + HALF_T) >>> (FRAC_BITS - 1));

      // Capture request fields
      if (ctrl.accept) begin
         scale_in = scale_factor;
      end
      if (ctrl.prev_take) begin
         prev_in = sample_value;
         h_in    = diff[33:1];
      end

      case (ctrl.step)
         ST_LOAD: begin
            zold_in = mem_rdata;
            b_in    = sat_word(sext_word(mem_rdata) + {{(PROD_W-33){h_ff[32]}}, h_ff});
         end
         ST_ADJ_D: begin
            case (ctrl.adj)
               ADJ_NEG:  d_in = -{zold_ff[31], zold_ff};
               ADJ_POS:  d_in = {zold_ff[31], zold_ff};
               ADJ_DIFF: d_in = {zold_ff[31], zold_ff} - {mem_rdata[31], mem_rdata};
               default:  d_in = {zold_ff[31], zold_ff};
            endcase
         end
         ST_CLAMP: begin
            if (t_raw > lim) begin
               t_in = lim;
            end else if (t_raw < -lim) begin
               t_in = -lim;
            end else begin
               t_in = t_raw;
            end
         end
         ST_ZBAR: begin
            zbar_in = sat_word(sext_word(b_ff) - ((prod_ff + HALF_F) >>> FRAC_BITS));
         end
         ST_MUL_R2: begin
            acc_in = prod_ff + HALF_F;
         end
         ST_SUM: begin
            res_in = sat_word((acc_ff + prod_ff) >>> FRAC_BITS);
         end
         ST_RND: begin
            res_in = sat_word((prod_ff + HALF_F) >>> FRAC_BITS);
         end
         default: begin
            res_in = res_ff;
         end
      endcase

      // Load the output register
      if (ctrl.emit) begin
         out_in = res_ff;
      end
   end

   // Previous sample is architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   // Working payload registers
   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      scale_ff <= scale_in;
      zold_ff  <= zold_in;
      b_ff     <= b_in;
      t_ff     <= t_in;
      zbar_ff  <= zbar_in;
      d_ff     <= d_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign mem_wdata    = (ctrl.step == ST_CLEAR) ? 32'sd0 : res_ff;
   assign result_value = out_ff;

endmodule

`default_nettype wire

@@ src/sdbp_seq.sv @@
// ----------------------------------------------------------------------------
// sdbp_seq
// Sequencer: request decode, memory addressing, step order and result control.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbp_seq #(
   parameter int MAX_POINTS = sdbp_pkg::SDBP_MAX_POINTS,
   parameter int AW         = $clog2(sdbp_pkg::SDBP_MAX_POINTS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sdbp_pkg::cfg_type    cfg,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [1:0]           req_operation,
   input  wire logic [9:0]           req_sample_index,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [9:0]           rsp_result_index,
   output      logic                 rsp_result_kind,
   output      sdbp_pkg::ctrl_type   ctrl,
   output      logic                 mem_wr_en,
   output      logic [AW-1:0]        mem_wr_addr,
   output      logic [AW-1:0]        mem_rd_addr
);

   import sdbp_pkg::*;

   localparam int LW = $clog2(MAX_POINTS + 1);
   localparam int CW = (LW > 11) ? LW : 11;

   step_type        state_ff, state_in;
   op_type          op_ff, op_in;
   adj_type         adj_ff, adj_in;
   logic [9:0]      ridx_ff, ridx_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [9:0]      rsp_idx_ff, rsp_idx_in;
   kind_type        rsp_kind_ff, rsp_kind_in;

   logic [CW-1:0]   vlen;
   logic [CW-1:0]   len;
   logic [CW-1:0]   idx_c;
   logic [9:0]      idx_m1;
   logic            idx_zero;
   logic            in_range;
   logic            scale_range;
   logic            accept;
   logic            out_free;
   logic            emit;
   op_type          req_op;
   kind_type        op_kind;

   // Effective waveform length
   always_comb begin
      vlen = CW'(cfg.vector_length);
      if (vlen < CW'(2)) begin
         len = CW'(2);
      end else if (vlen > CW'(MAX_POINTS)) begin
         len = CW'(MAX_POINTS);
      end else begin
         len = vlen;
      end
   end

   assign req_op      = op_type'(req_operation);
   assign idx_c       = CW'(req_sample_index);
   assign idx_m1      = req_sample_index - 10'd1;
   assign idx_zero    = (req_sample_index == 10'd0);
   assign in_range    = (idx_c < len);
   assign scale_range = (idx_c < (len - CW'(1)));

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == ST_DONE) && out_free;
   assign op_kind  = (op_ff == OP_ADJOINT) ? KIND_ADJOINT : KIND_DUAL;

   // Step sequencing
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      adj_in       = adj_ff;
      ridx_in      = ridx_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_kind_in  = rsp_kind_ff;
      mem_rd_addr  = AW'(ridx_ff);
      ctrl.prev_take = 1'b0;

      // Drop the result once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_POINTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_rd_addr = (req_op == OP_SCALE) ? AW'(req_sample_index)
                        : (idx_zero ? AW'(0) : AW'(idx_m1));
            if (accept) begin
               op_in = req_op;
               case (req_op)
                  OP_UPDATE: begin
                     if (in_range) begin
                        ctrl.prev_take = 1'b1;
                        ridx_in        = idx_m1;
                        if (!idx_zero) begin
                           state_in = ST_LOAD;
                        end
                     end
                  end
                  OP_ADJOINT: begin
                     ridx_in = req_sample_index;
                     if (idx_zero) begin
                        adj_in = ADJ_NEG;
                     end else if (idx_c == len - CW'(1)) begin
                        adj_in = ADJ_POS;
                     end else begin
                        adj_in = ADJ_DIFF;
                     end
                     if (in_range) begin
                        state_in = ST_LOAD;
                     end
                  end
                  OP_SCALE: begin
                     ridx_in = req_sample_index;
                     if (scale_range) begin
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            // Second neighbour read for the adjoint
            mem_rd_addr = AW'(ridx_ff);
            case (op_ff)
               OP_UPDATE:  state_in = ST_MUL_T;
               OP_ADJOINT: state_in = ST_ADJ_D;
               default:    state_in = ST_MUL_X;
            endcase
         end
         ST_ADJ_D:  state_in = ST_MUL_X;
         ST_MUL_T:  state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_MUL_S;
         ST_MUL_S:  state_in = ST_ZBAR;
         ST_ZBAR:   state_in = ST_MUL_R1;
         ST_MUL_R1: state_in = ST_MUL_R2;
         ST_MUL_R2: state_in = ST_SUM;
         ST_SUM:    state_in = ST_DONE;
         ST_MUL_X:  state_in = ST_RND;
         ST_RND:    state_in = ST_DONE;
         ST_DONE: begin
            // Hold until the output register is free
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = ridx_ff;
               rsp_kind_in  = op_kind;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ctrl.step     = state_ff;
      ctrl.adj      = adj_ff;
      ctrl.is_scale = (op_ff == OP_SCALE);
      ctrl.accept   = accept;
      ctrl.emit     = emit;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      adj_ff      <= adj_in;
      ridx_ff     <= ridx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign mem_wr_en        = (state_ff == ST_CLEAR) || (emit && (op_kind == KIND_DUAL));
   assign mem_wr_addr      = (state_ff == ST_CLEAR) ? clr_ff : AW'(ridx_ff);

endmodule

`default_nettype wire

@@ src/slew_dual_box_prox_update.sv @@
// ----------------------------------------------------------------------------
// slew_dual_box_prox_update
// Slew-rate dual update for a primal-dual box constraint (top level).
// ----------------------------------------------------------------------------
// One transaction is processed at a time through a single shared multiplier
// and one write and one read port on the dual memory. After reset the dual
// memory is cleared one entry per cycle, and requests stall until the clear
// is done. An update passes through one memory read, four passes through the
// multiplier, rounding stages and the write-back; an adjoint through two
// neighbour reads and one multiply; a scale through a read and a multiply.
// An update at index 0 or a dropped request is taken without leaving idle.
// A finished result sits in an output register; a request may be accepted
// while it waits, but the next result is held back until it is taken.
`default_nettype none

module slew_dual_box_prox_update #(
   parameter int MAX_POINTS = sdbp_pkg::SDBP_MAX_POINTS,
   parameter int FRAC_BITS  = sdbp_pkg::SDBP_FRAC_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [2:0]          csr_index,
   input  wire logic [30:0]         csr_wr_data,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [1:0]          req_operation,
   input  wire logic [9:0]          req_sample_index,
   input  wire logic signed [31:0]  req_sample_value,
   input  wire logic [30:0]         req_scale_factor,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [9:0]          rsp_result_index,
   output      logic signed [31:0]  rsp_result_value,
   output      logic                rsp_result_kind
);

   import sdbp_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);

   cfg_type              cfg_ff, cfg_in;
   ctrl_type             ctrl;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [AW-1:0]        mem_rd_addr;
   logic signed [31:0]   mem_wdata;
   logic signed [31:0]   mem_rdata;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WEIGHT:       cfg_in.weight        = csr_wr_data;
            CSR_DUAL_STEP:    cfg_in.dual_step     = csr_wr_data;
            CSR_CLAMP_LIMIT:  cfg_in.clamp_limit   = csr_wr_data;
            CSR_RELAX_FACTOR: cfg_in.relax_factor  = csr_wr_data[17:0];
            CSR_VECTOR_LEN:   cfg_in.vector_length = csr_wr_data[10:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight        <= WEIGHT_RST;
         cfg_ff.dual_step     <= DUAL_STEP_RST;
         cfg_ff.clamp_limit   <= CLAMP_LIMIT_RST;
         cfg_ff.relax_factor  <= RELAX_FACTOR_RST;
         cfg_ff.vector_length <= VECTOR_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdbp_seq #(
      .MAX_POINTS (MAX_POINTS),
      .AW         (AW)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_index (rsp_result_index),
      .rsp_result_kind  (rsp_result_kind),
      .ctrl             (ctrl),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_rd_addr      (mem_rd_addr)
   );

   sdbp_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .cfg          (cfg_ff),
      .sample_value (req_sample_value),
      .scale_factor (req_scale_factor),
      .mem_rdata    (mem_rdata),
      .mem_wdata    (mem_wdata),
      .result_value (rsp_result_value)
   );

   sdbp_dual_ram #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wdata),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

@@ bench/slew_dual_box_prox_update_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slew_dual_box_prox_update_checker
// Watches the request, result and register ports of the slew dual block,
// keeps its own copy of the dual vector and the registers, works out every
// result in order and compares each returned result field by field.
// ----------------------------------------------------------------------------

module slew_dual_box_prox_update_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_wr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [9:0]         req_sample_index,
   input  logic signed [31:0] req_sample_value,
   input  logic [30:0]        req_scale_factor,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [9:0]         rsp_result_index,
   input  logic signed [31:0] rsp_result_value,
   input  logic               rsp_result_kind,
   output int                 error_count,
   output int                 backlog,
   output int                 result_count
);

   import sdbp_pkg::*;

   localparam int     FRAC    = SDBP_FRAC_BITS;
   localparam int     POINTS  = SDBP_MAX_POINTS;
   localparam longint Q_MAX   = 64'sd2147483647;
   localparam longint Q_MIN   = -64'sd2147483647 - 64'sd1;
   localparam longint Q_ONE   = 64'sd1 <<< FRAC;

   typedef struct packed {
      logic [9:0]         position;
      logic signed [31:0] value;
      kind_type           kind;
   } dual_result_type;

   cfg_type            cfg;
   logic signed [31:0] dual_mirror [0:POINTS-1];
   logic signed [31:0] last_sample;
   dual_result_type    pending_results [$];

   initial begin
      error_count  = 0;
      backlog      = 0;
      result_count = 0;
   end

   // Saturate to a signed 32-bit word
   function automatic logic signed [31:0] clip32(input longint v);
      if (v > Q_MAX) begin
         return Q_MAX[31:0];
      end else if (v < Q_MIN) begin
         return Q_MIN[31:0];
      end
      return v[31:0];
   endfunction

   // Shift right, rounding to nearest with ties toward plus infinity
   function automatic longint round_shift(input longint v, input int unsigned s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Number of waveform points in use, with the length held to its range
   function automatic int unsigned active_len();
      int unsigned n;
      n = cfg.vector_length;
      if (n < 2) n = 2;
      if (n > POINTS) n = POINTS;
      return n;
   endfunction

   // Apply one accepted transaction to the mirror and queue its result
   task automatic predict_dual_op(input logic [1:0] op, input logic [9:0] idx,
                                  input logic signed [31:0] x,
                                  input logic [30:0] factor);
      int unsigned        len;
      longint             h;
      longint             zold;
      longint             lim;
      longint             neg_lim;
      longint             d;
      logic signed [31:0] b;
      logic signed [31:0] t;
      logic signed [31:0] zbar;
      logic signed [31:0] v;
      dual_result_type    r;
      len = active_len();
      case (op)
         OP_UPDATE: begin
            if (idx < len) begin
               if (idx == 0) begin
                  last_sample = x;
               end else begin
                  h = round_shift(longint'(x) - longint'(last_sample), 1);
                  last_sample = x;
                  zold = longint'(dual_mirror[idx - 10'd1]);
                  b = clip32(zold + h);
                  t = clip32(round_shift(longint'(b) * longint'(cfg.weight), FRAC - 1));
                  lim = longint'(cfg.clamp_limit);
                  neg_lim = -lim;
                  if (longint'(t) > lim) begin
                     t = lim[31:0];
                  end else if (longint'(t) < neg_lim) begin
                     t = neg_lim[31:0];
                  end
                  zbar = clip32(longint'(b)
                                - round_shift(longint'(cfg.dual_step) * longint'(t), FRAC));
                  v = clip32(round_shift(longint'(cfg.relax_factor) * longint'(zbar)
                                         + (Q_ONE - longint'(cfg.relax_factor)) * zold,
                                         FRAC));
                  dual_mirror[idx - 10'd1] = v;
                  r = '{position: idx - 10'd1, value: v, kind: KIND_DUAL};
                  pending_results.push_back(r);
               end
            end
         end
         OP_ADJOINT: begin
            if (idx < len) begin
               // end points see a single neighbor
               if (idx == 0) begin
                  d = -longint'(dual_mirror[0]);
               end else if (idx == len - 1) begin
                  d = longint'(dual_mirror[len - 2]);
               end else begin
                  d = longint'(dual_mirror[idx - 10'd1]) - longint'(dual_mirror[idx]);
               end
               v = clip32(round_shift(longint'(cfg.weight) * d, FRAC));
               r = '{position: idx, value: v, kind: KIND_ADJOINT};
               pending_results.push_back(r);
            end
         end
         OP_SCALE: begin
            if (idx < len - 1) begin
               v = clip32(round_shift(longint'(dual_mirror[idx]) * longint'(factor), FRAC));
               dual_mirror[idx] = v;
               r = '{position: idx, value: v, kind: KIND_DUAL};
               pending_results.push_back(r);
            end
         end
         default: begin
            // unused operation: drop
         end
      endcase
   endtask

   // Compare one returned result with the oldest one owed
   task automatic check_result();
      dual_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: ERROR result with none owed: index %0d value %0d kind %0d",
                  $time, rsp_result_index, rsp_result_value, rsp_result_kind);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         result_count++;
         if (rsp_result_index !== want.position) begin
            $display("%0t: ERROR result index: expected %0d, actual %0d",
                     $time, want.position, rsp_result_index);
            error_count++;
         end
         if (rsp_result_value !== want.value) begin
            $display("%0t: ERROR result value at index %0d: expected %0d, actual %0d",
                     $time, want.position, want.value, rsp_result_value);
            error_count++;
         end
         if (rsp_result_kind !== want.kind) begin
            $display("%0t: ERROR result kind at index %0d: expected %0d, actual %0d",
                     $time, want.position, want.kind, rsp_result_kind);
            error_count++;
         end
      end
   endtask

   // Track registers, transactions and results at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         cfg.weight        = WEIGHT_RST;
         cfg.dual_step     = DUAL_STEP_RST;
         cfg.clamp_limit   = CLAMP_LIMIT_RST;
         cfg.relax_factor  = RELAX_FACTOR_RST;
         cfg.vector_length = VECTOR_LEN_RST;
         for (int i = 0; i < POINTS; i++) dual_mirror[i] = '0;
         last_sample = '0;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WEIGHT:       cfg.weight        = csr_wr_data;
               CSR_DUAL_STEP:    cfg.dual_step     = csr_wr_data;
               CSR_CLAMP_LIMIT:  cfg.clamp_limit   = csr_wr_data;
               CSR_RELAX_FACTOR: cfg.relax_factor  = csr_wr_data[17:0];
               CSR_VECTOR_LEN:   cfg.vector_length = csr_wr_data[10:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_dual_op(req_operation, req_sample_index, req_sample_value,
                            req_scale_factor);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
      end
      backlog = pending_results.size();
   end

endmodule

@@ bench/slew_dual_box_prox_update_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slew_dual_box_prox_update_tb
// Drives the slew dual block with a short directed sequence and then random
// phases of ordered sample sweeps, adjoint and scale bursts and noise, each
// phase under a fresh register setting, with random gaps on both channels.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module slew_dual_box_prox_update_tb;
   import sdbp_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         WORK_TARGET  = 1800;
   localparam int         SETTLE_WAIT  = 16;
   localparam int         CYCLE_LIMIT  = 600000;

   logic               clock;
   logic               reset            = 1'b1;
   logic               csr_wr_en        = 1'b0;
   logic [2:0]         csr_index        = CSR_WEIGHT;
   logic [30:0]        csr_wr_data      = '0;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation    = OP_UPDATE;
   logic [9:0]         req_sample_index = '0;
   logic signed [31:0] req_sample_value = '0;
   logic [30:0]        req_scale_factor = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [9:0]         rsp_result_index;
   logic signed [31:0] rsp_result_value;
   logic               rsp_result_kind;

   int                 error_count;
   int                 backlog;
   int                 result_count;
   int                 cycle_count      = 0;
   bit                 gaps_on          = 1'b1;
   int unsigned        tb_len           = SDBP_MAX_POINTS;
   logic signed [31:0] walk_level       = '0;
   int                 sent_count       = 0;
   int                 work_count       = 0;
   int                 phase_count      = 0;

   slew_dual_box_prox_update dut (.*);

   slew_dual_box_prox_update_checker checker_0 (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Give up on a hung run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
   end

   // Stall the result channel now and then
   always @(negedge clock) rsp_stall <= gaps_on && ($urandom_range(0, 99) < 6);

   // Send one transaction; called and returns at a falling edge
   task automatic send(input logic [1:0] op, input logic [9:0] idx,
                       input logic signed [31:0] value, input logic [30:0] factor);
      while (gaps_on && $urandom_range(0, 99) < 6) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_operation    = op;
      req_sample_index = idx;
      req_sample_value = value;
      req_scale_factor = factor;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if ((op == OP_UPDATE || op == OP_ADJOINT) ? idx < tb_len
          : (op == OP_SCALE) ? idx < tb_len - 1 : 1'b0) begin
         work_count++;
      end
      @(negedge clock);
   endtask

   // Hold off the sender until every owed result has come back
   task automatic settle();
      req_valid = 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type which, input logic [30:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = which;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Load all registers once the block is idle
   task automatic configure(input logic [30:0] weight, input logic [30:0] step,
                            input logic [30:0] clamp, input logic [30:0] relax_word,
                            input logic [30:0] len_word);
      settle();
      write_csr(CSR_WEIGHT, weight);
      write_csr(CSR_DUAL_STEP, step);
      write_csr(CSR_CLAMP_LIMIT, clamp);
      write_csr(CSR_RELAX_FACTOR, relax_word);
      write_csr(CSR_VECTOR_LEN, len_word);
      tb_len = len_word[10:0];
      if (tb_len < 2) tb_len = 2;
      if (tb_len > SDBP_MAX_POINTS) tb_len = SDBP_MAX_POINTS;
      phase_count++;
   endtask

   function automatic logic [30:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 31'd0;
         1:       return 31'h7FFF_FFFF;
         2:       return 31'($urandom);
         3:       return 31'($urandom_range(0, 8 << 16));
         default: return 31'($urandom_range(16384, 262144));
      endcase
   endfunction

   // Next waveform sample: mostly a small step, sometimes a jump or an extreme
   function automatic logic signed [31:0] wander(input logic signed [31:0] from);
      longint step;
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: begin
            step = longint'($urandom_range(0, 524288)) - 64'sd262144;
            return 32'(longint'(from) + step);
         end
      endcase
   endfunction

   initial begin
      int unsigned last_idx;
      int          phase_goal;
      int          phase_start;
      int          burst;
      logic [17:0] relax;
      logic [10:0] len_field;
      logic [30:0] relax_word;
      logic [30:0] len_word;
      int          n;

      // Hold reset, then let the block finish clearing on its own handshake
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Extremes under the reset setting: first sample, top index, drops
      send(OP_UPDATE, 10'd0, 32'sh7FFF_FFFF, 31'd0);
      send(OP_UPDATE, 10'd1, 32'sh8000_0000, 31'd0);
      send(OP_UPDATE, 10'd1023, 32'sh0001_8000, 31'h7FFF_FFFF);
      send(OP_UPDATE, 10'd2, 32'sh0000_0000, 31'd0);
      send(OP_ADJOINT, 10'd0, 32'sh0, 31'd0);
      send(OP_ADJOINT, 10'd1023, 32'sh0, 31'd0);
      send(OP_ADJOINT, 10'd1, 32'sh0, 31'd0);
      send(OP_SCALE, 10'd0, 32'sh0, 31'h7FFF_FFFF);
      send(OP_SCALE, 10'd1022, 32'sh0, 31'd0);
      send(OP_SCALE, 10'd1023, 32'sh0, 31'd65536);
      send(OP_UNUSED, 10'd5, 32'shFFFF_FFFF, 31'h7FFF_FFFF);

      // Length below range, relaxation past two, widest weight and clamp
      configure(31'h7FFF_FFFF, 31'd32768, 31'h7FFF_FFFF, 31'h3FFFF, 31'd1);
      send(OP_UPDATE, 10'd0, -32'sd163840, 31'd0);
      send(OP_UPDATE, 10'd1, 32'sd196608, 31'd0);
      send(OP_UPDATE, 10'd2, 32'sd65536, 31'd0);
      send(OP_ADJOINT, 10'd0, 32'sh0, 31'd0);
      send(OP_ADJOINT, 10'd1, 32'sh0, 31'd0);
      send(OP_ADJOINT, 10'd2, 32'sh0, 31'd0);
      send(OP_SCALE, 10'd0, 32'sh0, 31'd98304);
      send(OP_SCALE, 10'd1, 32'sh0, 31'd65536);

      // Length above range, zero weight and relaxation, widest step
      configure(31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd0, 31'd2047);
      send(OP_UPDATE, 10'd1023, 32'sd65536, 31'd0);
      send(OP_ADJOINT, 10'd1023, 32'sh0, 31'd0);
      send(OP_UPDATE, 10'd500, -32'sd65536, 31'd0);
      send(OP_ADJOINT, 10'd500, 32'sh0, 31'd0);

      // Random phases, each under its own register setting
      work_count = 0;
      while (work_count < WORK_TARGET) begin
         case ($urandom_range(0, 5))
            0:       relax = 18'd0;
            1:       relax = 18'd131072;
            2:       relax = 18'd65536;
            3:       relax = 18'($urandom_range(0, 262143));
            default: relax = 18'($urandom_range(0, 131072));
         endcase
         case ($urandom_range(0, 9))
            0:       len_field = 11'($urandom_range(512, 1024));
            1:       len_field = $urandom_range(0, 1) ? 11'($urandom_range(0, 1))
                                                      : 11'($urandom_range(1025, 2047));
            default: len_field = 11'($urandom_range(2, 40));
         endcase
         relax_word = {13'd0, relax};
         len_word   = {20'd0, len_field};
         // junk in the unused upper bits must be ignored
         if ($urandom_range(0, 3) == 0) begin
            relax_word[30:18] = 13'($urandom);
            len_word[30:11]   = 20'($urandom);
         end
         configure(pick_word(), pick_word(), pick_word(), relax_word, len_word);
         gaps_on     = (phase_count % 4) != 1;
         phase_goal  = $urandom_range(60, 200);
         phase_start = work_count;

         while (work_count - phase_start < phase_goal && work_count < WORK_TARGET) begin
            n = $urandom_range(0, 99);
            if (n < 55) begin
               // ordered sweep from the first point
               last_idx = (tb_len > 64 && $urandom_range(0, 3) != 0)
                        ? $urandom_range(1, 64) : tb_len - 1;
               // keep the sweep within the remaining item budget
               if (last_idx >= WORK_TARGET - work_count) begin
                  last_idx = WORK_TARGET - work_count - 1;
               end
               for (int k = 0; k <= last_idx; k++) begin
                  walk_level = wander(walk_level);
                  send(OP_UPDATE, 10'(k), walk_level, 31'($urandom));
               end
            end else if (n < 70) begin
               burst = $urandom_range(1, 8);
               repeat (burst) begin
                  case ($urandom_range(0, 3))
                     0:       send(OP_ADJOINT, 10'd0, $urandom, 31'($urandom));
                     1:       send(OP_ADJOINT, 10'(tb_len - 1), $urandom, 31'($urandom));
                     default: send(OP_ADJOINT, 10'($urandom_range(0, tb_len - 1)),
                                   $urandom, 31'($urandom));
                  endcase
               end
            end else if (n < 80) begin
               burst = $urandom_range(1, 4);
               repeat (burst) begin
                  send(OP_SCALE, 10'($urandom_range(0, tb_len - 2)), $urandom,
                       ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(0, 131072)));
               end
            end else if (n < 88) begin
               // update out of order
               walk_level = wander(walk_level);
               send(OP_UPDATE, 10'($urandom_range(0, tb_len - 1)), walk_level,
                    31'($urandom));
            end else begin
               send(2'($urandom), 10'($urandom), $urandom, 31'($urandom));
            end
            if ($urandom_range(0, 39) == 0) settle();
         end
      end

      // Drain, bounded, then give the verdict
      req_valid = 1'b0;
      gaps_on   = 1'b0;
      for (n = 0; n < 4000 && backlog != 0; n++) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      $display("Covered %0d requests (%0d doing work) over %0d register settings,",
               sent_count, work_count, phase_count);
      $display("with %0d results compared in %0d cycles", result_count, cycle_count);
      if (error_count == 0 && backlog == 0) begin
         $display("No mismatches found");
      end else begin
         if (backlog != 0) $display("%0t: %0d expected results never came", $time, backlog);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/sdbp_pkg.sv
src/sdbp_dual_ram.sv
src/sdbp_datapath.sv
src/sdbp_seq.sv
src/slew_dual_box_prox_update.sv
bench/slew_dual_box_prox_update_checker.sv
bench/slew_dual_box_prox_update_tb.sv
